// ===== design/bounded_stack_with_bottom_increment_assert.svh =====
// Assertion macros for the bounded stack checker.
// Each macro takes a label, an antecedent, a consequent and a message string.
// They sample on clk_i and are disabled while rst_ni is low.
`ifndef BOUNDED_STACK_WITH_BOTTOM_INCREMENT_ASSERT_SVH
`define BOUNDED_STACK_WITH_BOTTOM_INCREMENT_ASSERT_SVH

// Same-cycle implication.
`define BSBI_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSBI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bsbi_pkg.sv =====
`timescale 1ns / 1ps

package bsbi_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int CAP_RESET     = 1024;
  localparam int WORD_W        = 32;
  localparam int CNT_IO_W      = 11;
  localparam int ACT_W         = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_INC  = 2'd2
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch item, launch memory reads
    logic commit;  // write memories, update count, load result
  } ctrl_cmd_t;

endpackage

// ===== design/bsbi_ctrl.sv =====
`timescale 1ns / 1ps

module bsbi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bsbi_pkg::ctrl_cmd_t cmd_o
);

  bsbi_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bsbi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bsbi_pkg::ST_EXEC;
        end
      end
      bsbi_pkg::ST_EXEC: begin
        if (slot_free) begin
          state_d = bsbi_pkg::ST_IDLE;
        end
      end
      default: state_d = bsbi_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.accept = 1'b0;
    cmd_o.commit = 1'b0;
    in_stall_o   = 1'b1;
    case (state_q)
      bsbi_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      bsbi_pkg::ST_EXEC: begin
        cmd_o.commit = slot_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsbi_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/bsbi_dpath.sv =====
`timescale 1ns / 1ps

module bsbi_dpath #(
  parameter int DEPTH = bsbi_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bsbi_pkg::ctrl_cmd_t          cmd_i,
  input  logic [bsbi_pkg::ACT_W-1:0]   action_i,
  input  logic signed [bsbi_pkg::WORD_W-1:0] push_value_i,
  input  logic [bsbi_pkg::CNT_IO_W-1:0] bottom_count_i,
  input  logic signed [bsbi_pkg::WORD_W-1:0] add_amount_i,
  input  logic                         cfg_we_i,
  input  logic [bsbi_pkg::CNT_IO_W-1:0] cfg_wdata_i,
  output logic signed [bsbi_pkg::WORD_W-1:0] pop_value_o,
  output logic                         pop_was_empty_o,
  output logic                         push_dropped_o,
  output logic [bsbi_pkg::CNT_IO_W-1:0] entry_count_o
);

  localparam int DW  = bsbi_pkg::WORD_W;
  localparam int IOW = bsbi_pkg::CNT_IO_W;
  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int WW  = (CW > IOW) ? CW : IOW;
  localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);
  localparam logic [WW-1:0] CAP_RST =
    WW'((bsbi_pkg::CAP_RESET < DEPTH) ? bsbi_pkg::CAP_RESET : DEPTH);

  // stack words and lazy increment deltas; delta of the top entry lives in delta_q
  logic [DW-1:0] stk_mem [DEPTH];
  logic [DW-1:0] inc_mem [DEPTH];

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [WW-1:0]     cap_q, cfg_w;
  logic [DW-1:0]     delta_q, delta_d;
  bsbi_pkg::action_e act_q;
  logic [DW-1:0]     val_q, amt_q;
  logic [WW-1:0]     n_q, n_in, k_in, cnt_w;
  logic [DW-1:0]     stk_rd_q, inc_rd_q;
  logic [AW-1:0]     stk_raddr, inc_raddr;

  logic              stk_we, inc_we;
  logic [AW-1:0]     stk_waddr, inc_waddr;
  logic [DW-1:0]     stk_wdata, inc_wdata;
  logic [DW-1:0]     res_pop;
  logic              res_empty, res_drop;

  assign cnt_w = WW'(cnt_q);
  assign k_in  = WW'(bottom_count_i);
  assign n_in  = (k_in < cnt_w) ? k_in : cnt_w;

  // read addresses from the incoming item
  always_comb begin
    stk_raddr = AW'(cnt_q - 1'b1);
    if (action_i == bsbi_pkg::ACT_POP) begin
      inc_raddr = AW'(cnt_q - 2'd2);
    end else begin
      inc_raddr = AW'(n_in - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q    <= bsbi_pkg::action_e'(action_i);
      val_q    <= push_value_i;
      amt_q    <= add_amount_i;
      n_q      <= n_in;
      stk_rd_q <= stk_mem[stk_raddr];
      inc_rd_q <= inc_mem[inc_raddr];
    end
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (inc_we) begin
      inc_mem[inc_waddr] <= inc_wdata;
    end
  end

  always_comb begin
    stk_we    = 1'b0;
    inc_we    = 1'b0;
    stk_waddr = AW'(cnt_q);
    inc_waddr = AW'(cnt_q - 1'b1);
    stk_wdata = val_q;
    inc_wdata = delta_q;
    cnt_d     = cnt_q;
    delta_d   = delta_q;
    res_pop   = '0;
    res_empty = 1'b0;
    res_drop  = 1'b0;
    case (act_q)
      bsbi_pkg::ACT_PUSH: begin
        if (cnt_w >= cap_q) begin
          res_drop = 1'b1;
        end else begin
          stk_we  = cmd_i.commit;
          inc_we  = cmd_i.commit && (cnt_q != '0);
          delta_d = '0;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      bsbi_pkg::ACT_POP: begin
        if (cnt_q == '0) begin
          res_pop   = '1;
          res_empty = 1'b1;
        end else begin
          res_pop = stk_rd_q + delta_q;
          delta_d = (cnt_q > CW'(1)) ? (inc_rd_q + delta_q) : '0;
          cnt_d   = cnt_q - 1'b1;
        end
      end
      bsbi_pkg::ACT_INC: begin
        if (n_q == '0) begin
          delta_d = delta_q;
        end else if (n_q == cnt_w) begin
          delta_d = delta_q + amt_q;
        end else begin
          inc_we    = cmd_i.commit;
          inc_waddr = AW'(n_q - 1'b1);
          inc_wdata = inc_rd_q + amt_q;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // capacity clipped to 1..DEPTH, taken only while empty
  always_comb begin
    cfg_w = WW'(cfg_wdata_i);
    if (cfg_w == '0) begin
      cfg_w = WW'(1);
    end else if (cfg_w > DEPTH_W) begin
      cfg_w = DEPTH_W;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cap_q <= CAP_RST;
    end else begin
      if (cmd_i.commit) begin
        cnt_q <= cnt_d;
      end
      if (cfg_we_i && (cnt_q == '0)) begin
        cap_q <= cfg_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      delta_q         <= delta_d;
      pop_value_o     <= res_pop;
      pop_was_empty_o <= res_empty;
      push_dropped_o  <= res_drop;
      entry_count_o   <= IOW'(cnt_d);
    end
  end

endmodule

// ===== design/bounded_stack_with_bottom_increment.sv =====
`timescale 1ns / 1ps
// Bounded LIFO stack of 32-bit signed words with push, pop and bottom increment.
// Input channel: in_valid_i / in_stall_o carry one beat per operation
//   (action_i, push_value_i, bottom_count_i, add_amount_i).
// Output channel: out_valid_o / out_stall_i carry one result beat per input beat
//   (pop_value_o, pop_was_empty_o, push_dropped_o, entry_count_o).
// Config: cfg_we_i writes cfg_wdata_i as the capacity (clipped to 1..DEPTH);
//   the write only lands while the stack is empty.
// Sequencing: an accepted beat moves to the execute state for the read-modify-write
//   of the two memories; its result is loaded into the output register when it
//   commits. The memories are read on accept and written on commit, and no new
//   beat is taken before that commit. in_stall_o is high during the execute state.
// Increments are lazy: only a per-entry delta at the boundary is touched, and a
//   pop folds the top delta into the word and hands it to the entry below.
// Stall: a new beat is taken while the previous result is still held; if the
//   result register is still occupied and stalled, execution waits there.
// Reset: asynchronous, active low. Count goes to zero, capacity to min(1024, DEPTH),
//   the output channel goes idle. Memory contents are not cleared.
module bounded_stack_with_bottom_increment #(
  parameter int DEPTH = bsbi_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bsbi_pkg::ACT_W-1:0]          action_i,
  input  logic signed [bsbi_pkg::WORD_W-1:0]  push_value_i,
  input  logic [bsbi_pkg::CNT_IO_W-1:0]       bottom_count_i,
  input  logic signed [bsbi_pkg::WORD_W-1:0]  add_amount_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bsbi_pkg::WORD_W-1:0]  pop_value_o,
  output logic                                pop_was_empty_o,
  output logic                                push_dropped_o,
  output logic [bsbi_pkg::CNT_IO_W-1:0]       entry_count_o,
  // capacity register
  input  logic                                cfg_we_i,
  input  logic [bsbi_pkg::CNT_IO_W-1:0]       cfg_wdata_i
);

  bsbi_pkg::ctrl_cmd_t cmd;

  // sequencing and output-register occupancy
  bsbi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // memories, count, top delta, capacity and result register
  bsbi_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (action_i),
    .push_value_i    (push_value_i),
    .bottom_count_i  (bottom_count_i),
    .add_amount_i    (add_amount_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .pop_value_o     (pop_value_o),
    .pop_was_empty_o (pop_was_empty_o),
    .push_dropped_o  (push_dropped_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

// ===== design/bsbi_chk.sv =====
`timescale 1ns / 1ps
`include "bounded_stack_with_bottom_increment_assert.svh"

module bsbi_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [bsbi_pkg::WORD_W-1:0]  pop_value_o,
  input logic                                pop_was_empty_o,
  input logic                                push_dropped_o,
  input logic [bsbi_pkg::CNT_IO_W-1:0]       entry_count_o
);

  // stalled result beat holds
  `BSBI_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(pop_value_o) && $stable(entry_count_o) &&
    $stable(pop_was_empty_o) && $stable(push_dropped_o),
    "stalled result beat changed")

  // empty pop: -1, count zero, no drop flag
  `BSBI_ASSERT_IMM(a_empty_pop, out_valid_o && pop_was_empty_o,
    (pop_value_o == -32'sd1) && (entry_count_o == '0) && !push_dropped_o,
    "empty pop result malformed")

  // dropped push: stack was full, so count is nonzero and no pop data
  `BSBI_ASSERT_IMM(a_drop, out_valid_o && push_dropped_o,
    (entry_count_o != '0) && (pop_value_o == '0),
    "dropped push result malformed")

  // one beat in execution at a time
  `BSBI_ASSERT_NXT(a_busy, in_valid_i && !in_stall_o, in_stall_o,
    "input taken back to back")

endmodule

bind bounded_stack_with_bottom_increment bsbi_chk u_bsbi_chk (.*);

// ===== bench/stack_result_checker.sv =====
`timescale 1ns / 1ps

module stack_result_checker #(
  parameter int DEPTH = bsbi_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [bsbi_pkg::ACT_W-1:0]           action_i,
  input  logic [bsbi_pkg::WORD_W-1:0]          push_value_i,
  input  logic [bsbi_pkg::CNT_IO_W-1:0]        bottom_count_i,
  input  logic [bsbi_pkg::WORD_W-1:0]          add_amount_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [bsbi_pkg::WORD_W-1:0]          pop_value_i,
  input  logic                                 pop_was_empty_i,
  input  logic                                 push_dropped_i,
  input  logic [bsbi_pkg::CNT_IO_W-1:0]        entry_count_i,
  input  logic                                 cfg_we_i,
  input  logic [bsbi_pkg::CNT_IO_W-1:0]        cfg_wdata_i,
  output int                                   pending_o,
  output int                                   held_o,
  output int                                   fail_count_o
);

  typedef struct packed {
    logic [bsbi_pkg::WORD_W-1:0]   pop_value;
    logic                          pop_was_empty;
    logic                          push_dropped;
    logic [bsbi_pkg::CNT_IO_W-1:0] entry_count;
  } stack_result_t;

  logic [bsbi_pkg::WORD_W-1:0] words [DEPTH];
  int unsigned   held;
  int unsigned   capacity;
  int            fails;
  stack_result_t result_q [$];

  function automatic int unsigned clip_capacity(input int unsigned v);
    if (v == 0) return 1;
    if (v > DEPTH) return DEPTH;
    return v;
  endfunction

  task automatic predict_stack_op(input logic [bsbi_pkg::ACT_W-1:0] act,
                                  input logic [bsbi_pkg::WORD_W-1:0] pv,
                                  input logic [bsbi_pkg::CNT_IO_W-1:0] bc,
                                  input logic [bsbi_pkg::WORD_W-1:0] aa);
    stack_result_t r;
    int unsigned   n;
    r = '0;
    case (act)
      bsbi_pkg::ACT_PUSH: begin
        if (held >= capacity) begin
          r.push_dropped = 1'b1;
        end else begin
          words[held] = pv;
          held++;
        end
      end
      bsbi_pkg::ACT_POP: begin
        if (held == 0) begin
          r.pop_value     = '1;
          r.pop_was_empty = 1'b1;
        end else begin
          held--;
          r.pop_value = words[held];
        end
      end
      bsbi_pkg::ACT_INC: begin
        n = (bc < held) ? bc : held;
        for (int i = 0; i < n; i++) words[i] += aa;
      end
      default: ;  // unused code: no change
    endcase
    r.entry_count = held[bsbi_pkg::CNT_IO_W-1:0];
    result_q.push_back(r);
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t ns: %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t want;
    if (!rst_ni) begin
      held     = 0;
      capacity = clip_capacity(bsbi_pkg::CAP_RESET);
      fails    = 0;
      result_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          fails++;
          $display("%0t ns: result beat expected none actual entry_count %0d",
                   $time, entry_count_i);
        end else begin
          want = result_q.pop_front();
          compare_field("pop_value", want.pop_value, pop_value_i);
          compare_field("pop_was_empty", 32'(want.pop_was_empty),
                        32'(pop_was_empty_i));
          compare_field("push_dropped", 32'(want.push_dropped),
                        32'(push_dropped_i));
          compare_field("entry_count", 32'(want.entry_count), 32'(entry_count_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_stack_op(action_i, push_value_i, bottom_count_i, add_amount_i);
      // capacity only lands while empty
      if (cfg_we_i && held == 0) capacity = clip_capacity(32'(cfg_wdata_i));
    end
    pending_o    <= result_q.size();
    held_o       <= held;
    fail_count_o <= fails;
  end

endmodule

// ===== bench/bounded_stack_with_bottom_increment_test.sv =====
`timescale 1ns / 1ps

module bounded_stack_with_bottom_increment_test;

  localparam int DEPTH = bsbi_pkg::DEPTH_DEFAULT;

  // action code the block must ignore
  localparam logic [bsbi_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int PHASE_BEATS = 70;  // per random phase: half filling, half draining
  localparam int HOLD_CYCLES = 60;  // long receiver hold-off

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic                                in_valid     = 1'b0;
  logic                                in_stall;
  logic [bsbi_pkg::ACT_W-1:0]          action       = '0;
  logic signed [bsbi_pkg::WORD_W-1:0]  push_value   = '0;
  logic [bsbi_pkg::CNT_IO_W-1:0]       bottom_count = '0;
  logic signed [bsbi_pkg::WORD_W-1:0]  add_amount   = '0;

  // output channel
  logic                                out_valid;
  logic                                out_stall    = 1'b0;
  logic signed [bsbi_pkg::WORD_W-1:0]  pop_value;
  logic                                pop_was_empty;
  logic                                push_dropped;
  logic [bsbi_pkg::CNT_IO_W-1:0]       entry_count;

  // capacity register
  logic                                cfg_we       = 1'b0;
  logic [bsbi_pkg::CNT_IO_W-1:0]       cfg_wdata    = '0;

  // from the checker: beats in flight, predicted fill level, mismatches
  int pending;
  int held;
  int fail_count;

  // stimulus shaping, written by the stimulus process only
  bit idle_on   = 1'b1;
  int hold_asks = 0;
  // owned by the receiver process
  int hold_served = 0;

  int caps [10] = '{3, 1, 16, 2047, 7, 0, 40, 1025, 2, 1024};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bounded_stack_with_bottom_increment #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .push_value_i   (push_value),
    .bottom_count_i (bottom_count),
    .add_amount_i   (add_amount),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pop_value_o    (pop_value),
    .pop_was_empty_o(pop_was_empty),
    .push_dropped_o (push_dropped),
    .entry_count_o  (entry_count),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  stack_result_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (action),
    .push_value_i   (push_value),
    .bottom_count_i (bottom_count),
    .add_amount_i   (add_amount),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pop_value_i    (pop_value),
    .pop_was_empty_i(pop_was_empty),
    .push_dropped_i (push_dropped),
    .entry_count_i  (entry_count),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .pending_o      (pending),
    .held_o         (held),
    .fail_count_o   (fail_count)
  );

  // Word values: extremes now and then, otherwise uniform.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Increment reach: mostly around the current fill level so partial and
  // full-depth increments both happen, sometimes the full depth of 1024.
  function automatic logic [10:0] pick_reach();
    case ($urandom_range(5))
      0:       return 11'd1024;
      1:       return 11'($urandom_range(1024));
      default: return 11'($urandom_range((held + 1 > 1024) ? 1024 : held + 1));
    endcase
  endfunction

  // Offer one beat and return at the edge that accepts it. Valid stays high
  // afterwards so back-to-back beats go out without a bubble.
  task automatic issue_op(input logic [bsbi_pkg::ACT_W-1:0] act,
                          input logic [31:0] pv, input logic [10:0] bc,
                          input logic [31:0] aa);
    if (idle_on && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    push_value   <= pv;
    bottom_count <= bc;
    add_amount   <= aa;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every result has come back. The first edge
  // lets the checker count a beat accepted on the edge we were called at.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [10:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Pop everything so the next capacity write actually lands.
  task automatic set_capacity(input logic [10:0] v);
    int n;
    wait_idle();
    n = held;
    repeat (n) issue_op(bsbi_pkg::ACT_POP, $urandom, 11'($urandom), $urandom);
    write_capacity(v);
  endtask

  // One random beat. While filling, pushes dominate so the stack reaches its
  // capacity and pushes get dropped; while draining, pops dominate so it runs
  // dry and empty pops happen. Unused fields carry random junk throughout.
  task automatic random_op(input bit filling);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6)
      issue_op(ACT_UNUSED, pick_word(), 11'($urandom_range(1024)), pick_word());
    else if (pick < (filling ? 60 : 25))
      issue_op(bsbi_pkg::ACT_PUSH, pick_word(), 11'($urandom_range(1024)), $urandom);
    else if (pick < 80)
      issue_op(bsbi_pkg::ACT_POP, $urandom, 11'($urandom_range(1024)), $urandom);
    else
      issue_op(bsbi_pkg::ACT_INC, $urandom, pick_reach(), pick_word());
  endtask

  // Receiver: random stall bursts, plus a long hold-off whenever the
  // stimulus asks for one, which backs the block up into its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served < hold_asks) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(6, 1)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty stack corners at the reset capacity.
    issue_op(bsbi_pkg::ACT_POP, '0, '0, '0);              // pop while empty
    issue_op(bsbi_pkg::ACT_INC, '0, 11'd5, 32'd7);        // increment while empty
    issue_op(ACT_UNUSED, 32'h1234_5678, 11'd3, 32'd9);    // unused code, empty

    // Word extremes, then increments that wrap and one clipped to the count.
    issue_op(bsbi_pkg::ACT_PUSH, 32'h7fff_ffff, '0, '0);
    issue_op(bsbi_pkg::ACT_PUSH, 32'h8000_0000, '1, '1);
    issue_op(bsbi_pkg::ACT_PUSH, 32'h0000_0000, '0, '0);
    issue_op(bsbi_pkg::ACT_PUSH, 32'hffff_ffff, '0, '0);
    issue_op(bsbi_pkg::ACT_INC, '0, 11'd0, 32'd123);      // zero reach: no-op
    issue_op(bsbi_pkg::ACT_INC, '0, 11'd2, 32'd1);        // bottom max wraps
    issue_op(bsbi_pkg::ACT_INC, '0, 11'd1024, 32'h8000_0000);
    issue_op(bsbi_pkg::ACT_INC, '0, 11'd3, 32'h7fff_ffff);
    issue_op(ACT_UNUSED, $urandom, 11'd1024, $urandom);   // unused code, non-empty
    repeat (4) issue_op(bsbi_pkg::ACT_POP, '0, '0, '0);
    issue_op(bsbi_pkg::ACT_POP, '0, '0, '0);              // empty again

    // Zero capacity clips to one: second push is dropped.
    set_capacity(11'd0);
    issue_op(bsbi_pkg::ACT_PUSH, 32'd5, '0, '0);
    issue_op(bsbi_pkg::ACT_PUSH, 32'd6, '0, '0);
    // Capacity write while holding an entry must be ignored.
    write_capacity(11'd5);
    issue_op(bsbi_pkg::ACT_PUSH, 32'd7, '0, '0);
    issue_op(bsbi_pkg::ACT_POP, '0, '0, '0);

    // Random phases, each at its own capacity. Phase 4 runs with no idling;
    // the last two are the quiet tail. Two phases start under a long hold.
    foreach (caps[p]) begin
      set_capacity(11'(caps[p]));
      idle_on <= !(p == 4 || p >= 8);
      if (p == 1 || p == 6) hold_asks <= hold_asks + 1;
      for (int k = 0; k < PHASE_BEATS; k++) random_op(k < PHASE_BEATS / 2);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("bounded_stack_with_bottom_increment_test passed");
    else
      $display("bounded_stack_with_bottom_increment_test failed");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("bounded_stack_with_bottom_increment_test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/bsbi_pkg.sv
design/bsbi_ctrl.sv
design/bsbi_dpath.sv
design/bounded_stack_with_bottom_increment.sv
design/bsbi_chk.sv
bench/stack_result_checker.sv
bench/bounded_stack_with_bottom_increment_test.sv
